>>> hw/rtl/cdu_pkg.sv
package cdu_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 40;
    localparam int RAW_W     = 48;
    localparam int ITEM_T_W  = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKSTEP_GAP = 2'd0,
        CFG_COINC_WINDOW = 2'd1,
        CFG_SEARCH_START = 2'd2,
        CFG_ERROR_LIMIT  = 2'd3
    } cdu_cfg_e;

    localparam logic [CFG_W-1:0] RST_BACKSTEP_GAP = 40'd10000000;
    localparam logic [CFG_W-1:0] RST_COINC_WINDOW = 40'd100;
    localparam logic [CFG_W-1:0] RST_SEARCH_START = 40'd900000000000;
    localparam logic [CFG_W-1:0] RST_ERROR_LIMIT  = 40'd800000000000;

    localparam logic [1:0] CH_TRIGGER = 2'd1;
    localparam logic [1:0] CH_PARTNER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_SHIFT,
        ST_SEARCH,
        ST_OUT
    } cdu_state_t;

    typedef struct packed {
        logic [1:0]       hit_channel;
        logic [RAW_W-1:0] raw_time;
    } cdu_in_t;

    typedef struct packed {
        logic [1:0]          item_channel;
        logic [ITEM_T_W-1:0] item_time;
        logic                was_checked;
        logic [CFG_W-1:0]    nearest_gap;
        logic                is_coincident;
        logic                no_partner;
    } cdu_out_t;

    // Running minimum that travels down the row of cells behind a token.
    typedef struct packed {
        logic             tok;
        logic [CFG_W-1:0] nearest;
    } cdu_srch_t;

endpackage

>>> hw/rtl/two_channel_coincidence_detector_unit.sv
// Two-channel coincidence detector.
// Hit requests arrive on in_valid/in_stall/in_data and carry a channel and
// a raw 48-bit timestamp. Corrected hits shift through a row of
// 2*HALF_SPAN+2 cells and each result describes the hit HALF_SPAN+1
// requests back, so the first HALF_SPAN+1 requests give no result.
// A channel-1 hit with a full window behind it is checked: a running
// minimum walks the row one cell per cycle and picks up the nearest
// channel-2 hit among the HALF_SPAN neighbors on each side.
// One request is handled at a time. Each hit passes the step and shift
// states; a checked hit then waits in the search state for the walk along
// the row, and a hit with a result is loaded into the output register in
// the output state. The input takes the next request once the block is
// idle again: after that load, or after the shift when no result is due.
// Results leave on out_valid/out_stall/out_data from an output register;
// while the receiver stalls, a new request is still taken and worked on,
// and it waits for the output register only at its very end.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while idle; the block does not enforce it. Reset clears
// the offset, previous time, hit count and restores the register defaults.
module two_channel_coincidence_detector_unit
    import cdu_pkg::*;
#(
    parameter int HALF_SPAN = 8,
    parameter int TIME_BITS = 56
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cdu_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cdu_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int WIN  = 2 * HALF_SPAN + 2;
    localparam int DLY  = HALF_SPAN + 1;
    localparam int CNTW = $clog2(WIN + 1);
    localparam logic [64:0]      TMAX65 = (65'd1 << TIME_BITS) - 65'd1;
    localparam logic [CNTW-1:0]  WIN_C  = CNTW'(WIN);
    localparam logic [CNTW-1:0]  DLY_C  = CNTW'(DLY);

    cdu_state_t           state_reg, state_next;

    logic [CFG_W-1:0]     gap_reg, win_reg, start_cfg_reg, limit_reg;
    logic [TIME_BITS-1:0] offset_reg, prev_reg;
    logic [CNTW-1:0]      seen_reg;
    logic                 start_reg, start_next;
    logic                 checked_reg;
    logic                 out_valid_reg;
    cdu_out_t             out_reg;

    logic [1:0]           chan_reg;
    logic [TIME_BITS-1:0] corr_reg;
    logic                 back_reg;
    logic [TIME_BITS-1:0] diff_reg, alt_reg;
    logic [CFG_W-1:0]     nearest_reg;

    logic [64:0]          raw_c, corr_sum, alt_sum, off_sum;
    logic [TIME_BITS-1:0] corr_sat, alt_sat, off_sat, hit_time;
    logic                 shift_en;
    logic                 accept_in;
    logic                 out_free;
    logic                 will_check;
    cdu_srch_t            srch_head, srch_tail;
    logic [TIME_BITS-1:0] rep_time;
    logic [1:0]           rep_chan, pre_chan;
    logic [63:0]          rep_time64;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= RST_BACKSTEP_GAP;
            win_reg       <= RST_COINC_WINDOW;
            start_cfg_reg <= RST_SEARCH_START;
            limit_reg     <= RST_ERROR_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cdu_cfg_e'(cfg_index))
                CFG_BACKSTEP_GAP: gap_reg       <= cfg_data;
                CFG_COINC_WINDOW: win_reg       <= cfg_data;
                CFG_SEARCH_START: start_cfg_reg <= cfg_data;
                CFG_ERROR_LIMIT:  limit_reg     <= cfg_data;
            endcase
        end
    end

    // Saturating time arithmetic, carried out in 65-bit sums.
    always_comb
    begin
        raw_c    = (65'(in_data.raw_time) > TMAX65) ? TMAX65 : 65'(in_data.raw_time);
        corr_sum = raw_c + 65'(offset_reg);
        corr_sat = (corr_sum > TMAX65) ? TMAX65[TIME_BITS-1:0] : corr_sum[TIME_BITS-1:0];
        alt_sum  = 65'(prev_reg) + 65'(gap_reg);
        alt_sat  = (alt_sum > TMAX65) ? TMAX65[TIME_BITS-1:0] : alt_sum[TIME_BITS-1:0];
        off_sum  = 65'(offset_reg) + 65'(diff_reg);
        off_sat  = (off_sum > TMAX65) ? TMAX65[TIME_BITS-1:0] : off_sum[TIME_BITS-1:0];
        hit_time = back_reg ? alt_reg : corr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            chan_reg <= in_data.hit_channel;
            corr_reg <= corr_sat;
        end
        if (state_reg == ST_STEP)
        begin
            back_reg <= (corr_reg < prev_reg);
            diff_reg <= prev_reg - corr_reg;
            alt_reg  <= alt_sat;
        end
        if (state_reg == ST_SEARCH && srch_tail.tok)
        begin
            nearest_reg <= srch_tail.nearest;
        end
    end

    assign shift_en   = (state_reg == ST_SHIFT);
    // The entry one place short of the report point moves there on this shift.
    assign will_check = (seen_reg == WIN_C) && (pre_chan == CH_TRIGGER);

    assign srch_head.tok     = start_reg;
    assign srch_head.nearest = start_cfg_reg;

    cdu_chain #(
        .HALF_SPAN (HALF_SPAN),
        .TIME_BITS (TIME_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .new_time  (hit_time),
        .new_chan  (chan_reg),
        .srch_head (srch_head),
        .srch_tail (srch_tail),
        .rep_time  (rep_time),
        .rep_chan  (rep_chan),
        .pre_chan  (pre_chan)
    );

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                priority if (seen_reg < DLY_C)
                begin
                    state_next = ST_IDLE;
                end
                else if (will_check)
                begin
                    state_next = ST_SEARCH;
                    start_next = 1'b1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SEARCH:
            begin
                if (srch_tail.tok)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            checked_reg   <= 1'b0;
            offset_reg    <= '0;
            prev_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            if (state_reg == ST_STEP)
            begin
                prev_reg <= corr_reg;
            end
            if (shift_en)
            begin
                checked_reg <= will_check;
                if (back_reg)
                begin
                    offset_reg <= off_sat;
                end
                if (seen_reg < WIN_C)
                begin
                    seen_reg <= seen_reg + CNTW'(1);
                end
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rep_time64 = 64'(rep_time);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg.item_channel  <= rep_chan;
            out_reg.item_time     <= rep_time64[ITEM_T_W-1:0];
            out_reg.was_checked   <= checked_reg;
            out_reg.nearest_gap   <= checked_reg ? nearest_reg : '0;
            out_reg.is_coincident <= checked_reg && (nearest_reg < win_reg);
            out_reg.no_partner    <= checked_reg && (nearest_reg > limit_reg);
        end
    end

endmodule

>>> hw/rtl/cdu_cell.sv
module cdu_cell
    import cdu_pkg::*;
#(
    parameter int  TIME_BITS = 56,
    parameter bit  ELIGIBLE  = 1'b1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [TIME_BITS-1:0] time_in,
    input  logic [1:0]           chan_in,
    output logic [TIME_BITS-1:0] time_out,
    output logic [1:0]           chan_out,
    input  logic [TIME_BITS-1:0] ref_time,
    input  cdu_srch_t            srch_in,
    output cdu_srch_t            srch_out
);

    logic [TIME_BITS-1:0] time_reg;
    logic [1:0]           chan_reg;
    logic [TIME_BITS-1:0] delta;
    logic                 closer;
    cdu_srch_t            srch_reg;
    cdu_srch_t            srch_next;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            time_reg <= time_in;
            chan_reg <= chan_in;
        end
    end

    always_comb
    begin
        delta = (time_reg >= ref_time) ? (time_reg - ref_time) : (ref_time - time_reg);
        closer = ELIGIBLE && srch_in.tok && (chan_reg == CH_PARTNER)
                 && (64'(delta) < 64'(srch_in.nearest));
        srch_next.tok = srch_in.tok;
        srch_next.nearest = closer ? CFG_W'(delta) : srch_in.nearest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign time_out = time_reg;
    assign chan_out = chan_reg;
    assign srch_out = srch_reg;

endmodule

>>> hw/rtl/cdu_chain.sv
module cdu_chain
    import cdu_pkg::*;
#(
    parameter int HALF_SPAN = 8,
    parameter int TIME_BITS = 56
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic [1:0]           new_chan,
    input  cdu_srch_t            srch_head,
    output cdu_srch_t            srch_tail,
    output logic [TIME_BITS-1:0] rep_time,
    output logic [1:0]           rep_chan,
    output logic [1:0]           pre_chan
);

    localparam int WIN = 2 * HALF_SPAN + 2;
    localparam int DLY = HALF_SPAN + 1;

    logic [TIME_BITS-1:0] time_link [0:WIN];
    logic [1:0]           chan_link [0:WIN];
    cdu_srch_t            srch_link [0:WIN];

    assign time_link[0] = new_time;
    assign chan_link[0] = new_chan;
    assign srch_link[0] = srch_head;

    // Cell i holds the hit i places back; only the newest entry takes no
    // part in the partner search.
    for (genvar i = 0; i < WIN; i++)
    begin : g_cell
        cdu_cell #(
            .TIME_BITS (TIME_BITS),
            .ELIGIBLE  ((i >= 1) && (i <= 2 * HALF_SPAN + 1))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .time_in  (time_link[i]),
            .chan_in  (chan_link[i]),
            .time_out (time_link[i+1]),
            .chan_out (chan_link[i+1]),
            .ref_time (rep_time),
            .srch_in  (srch_link[i]),
            .srch_out (srch_link[i+1])
        );
    end

    assign rep_time  = time_link[DLY+1];
    assign rep_chan  = chan_link[DLY+1];
    assign pre_chan  = chan_link[DLY];
    assign srch_tail = (time_link[WIN] == time_link[WIN] && chan_link[WIN] == chan_link[WIN])
                       ? srch_link[WIN] : srch_link[WIN];

endmodule

>>> bench/two_channel_coincidence_detector_unit_tb.sv
`timescale 1ns / 1ps

module two_channel_coincidence_detector_unit_tb;
    import cdu_pkg::*;

    localparam int HALF_SPAN  = 8;
    localparam int WIN_DEPTH  = 2 * HALF_SPAN + 2;
    localparam int REPORT_LAG = HALF_SPAN + 1;
    localparam logic [63:0] TIME_MAX = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;
    localparam logic [1:0] CH_SPARE_LO = 2'd0;
    localparam logic [1:0] CH_SPARE_HI = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int STUCK_LIMIT   = 4000;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    cdu_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    cdu_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BACKSTEP_GAP;
    logic [CFG_W-1:0] cfg_data = '0;

    two_channel_coincidence_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted state of the detector.
    logic [63:0] hit_times [WIN_DEPTH] = '{default: '0};
    logic [1:0]  hit_chans [WIN_DEPTH] = '{default: '0};
    logic [63:0] time_offs = '0;
    logic [63:0] last_corr = '0;
    int          hit_count = 0;
    logic [CFG_W-1:0] reg_gap    = RST_BACKSTEP_GAP;
    logic [CFG_W-1:0] reg_window = RST_COINC_WINDOW;
    logic [CFG_W-1:0] reg_start  = RST_SEARCH_START;
    logic [CFG_W-1:0] reg_limit  = RST_ERROR_LIMIT;

    cdu_out_t expected_reports [$];
    int errors = 0;

    bit in_idle_en = 1'b0;
    bit stall_en   = 1'b0;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int hold_left  = 0;
    int burst_left = 0;
    logic [RAW_W-1:0] cur_raw = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] sat_time(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] x;
        logic [63:0] y;
        x = (a > TIME_MAX) ? TIME_MAX : a;
        y = (b > TIME_MAX) ? TIME_MAX : b;
        return (x + y > TIME_MAX) ? TIME_MAX : x + y;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit predict_report(input cdu_in_t hit, output cdu_out_t rep);
        logic [63:0] corr;
        logic [63:0] stamp;
        logic [63:0] nearest;
        logic [63:0] gap_ticks;
        int prior;
        bit checked;
        rep = '0;
        corr = sat_time({16'd0, hit.raw_time}, time_offs);
        if (corr >= last_corr)
            stamp = corr;
        else
        begin
            stamp = sat_time(last_corr, {24'd0, reg_gap});
            time_offs = sat_time(time_offs, last_corr - corr);
        end
        last_corr = corr;
        for (int d = WIN_DEPTH - 1; d > 0; d--)
        begin
            hit_times[d] = hit_times[d - 1];
            hit_chans[d] = hit_chans[d - 1];
        end
        hit_times[0] = stamp;
        hit_chans[0] = hit.hit_channel;
        prior = hit_count;
        if (hit_count < WIN_DEPTH)
            hit_count++;
        if (prior < REPORT_LAG)
            return 1'b0;

        checked = (hit_chans[REPORT_LAG] == CH_TRIGGER) && (prior >= WIN_DEPTH);
        nearest = '0;
        if (checked)
        begin
            nearest = {24'd0, reg_start};
            for (int d = 1; d < WIN_DEPTH; d++)
            begin
                if (hit_chans[d] == CH_PARTNER)
                begin
                    gap_ticks = (hit_times[d] >= hit_times[REPORT_LAG])
                              ? hit_times[d] - hit_times[REPORT_LAG]
                              : hit_times[REPORT_LAG] - hit_times[d];
                    if (gap_ticks < nearest)
                        nearest = gap_ticks;
                end
            end
            rep.is_coincident = nearest < {24'd0, reg_window};
            rep.no_partner    = nearest > {24'd0, reg_limit};
        end
        rep.item_channel = hit_chans[REPORT_LAG];
        rep.item_time    = hit_times[REPORT_LAG][ITEM_T_W-1:0];
        rep.was_checked  = checked;
        rep.nearest_gap  = nearest[CFG_W-1:0];
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("time %0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        cdu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("time %0t: unexpected result, expected none, actual %0h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("item_channel", 64'(want.item_channel),
                            64'(out_data.item_channel));
                check_field("item_time", 64'(want.item_time), 64'(out_data.item_time));
                check_field("was_checked", 64'(want.was_checked),
                            64'(out_data.was_checked));
                check_field("nearest_gap", 64'(want.nearest_gap),
                            64'(out_data.nearest_gap));
                check_field("is_coincident", 64'(want.is_coincident),
                            64'(out_data.is_coincident));
                check_field("no_partner", 64'(want.no_partner), 64'(out_data.no_partner));
            end
        end
    end

    // Receiver stall: random bursts, plus a long hold when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_reqs != hold_done)
        begin
            out_stall <= 1'b1;
            hold_left = LONG_HOLD - 1;
            hold_done++;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else if (stall_en && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            burst_left = $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk)
    begin
        int stuck;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("time %0t: no progress for %0d cycles", $time, stuck);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_hit(input logic [1:0] chan, input logic [RAW_W-1:0] raw);
        cdu_out_t rep;
        if (in_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{hit_channel: chan, raw_time: raw};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_report(in_data, rep))
            expected_reports = {expected_reports, rep};
    endtask

    // Waits for every expected result, then for any request still in flight.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cdu_cfg_e idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BACKSTEP_GAP: reg_gap    = value;
            CFG_COINC_WINDOW: reg_window = value;
            CFG_SEARCH_START: reg_start  = value;
            CFG_ERROR_LIMIT:  reg_limit  = value;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] win,
                             input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] lim);
        settle_block();
        write_reg(CFG_BACKSTEP_GAP, gap);
        write_reg(CFG_COINC_WINDOW, win);
        write_reg(CFG_SEARCH_START, start);
        write_reg(CFG_ERROR_LIMIT, lim);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly rising times with small steps, now and then a step backward.
    function automatic logic [RAW_W-1:0] advance_time(input int step_max);
        if ($urandom_range(0, 29) == 0)
            cur_raw = cur_raw - RAW_W'($urandom_range(1, 100000));
        else
            cur_raw = cur_raw + RAW_W'($urandom_range(0, step_max));
        return cur_raw;
    endfunction

    function automatic logic [1:0] pick_channel(input int partner_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CH_TRIGGER;
        if (r < 45 + partner_pct)
            return CH_PARTNER;
        return $urandom_range(0, 1) ? CH_SPARE_HI : CH_SPARE_LO;
    endfunction

    task automatic stream_hits(input int count, input int step_max, input int partner_pct);
        for (int i = 0; i < count; i++)
            send_hit(pick_channel(partner_pct), advance_time(step_max));
    endtask

    task automatic test_directed();
        logic [1:0] chans [25];
        logic [RAW_W-1:0] stamps [25];
        chans = '{CH_SPARE_LO, CH_TRIGGER, CH_PARTNER, CH_SPARE_HI, CH_TRIGGER,
                  CH_PARTNER, CH_PARTNER, CH_TRIGGER, CH_PARTNER, CH_TRIGGER,
                  CH_PARTNER, CH_SPARE_LO, CH_TRIGGER, CH_PARTNER, CH_TRIGGER,
                  CH_SPARE_HI, CH_TRIGGER, CH_PARTNER, CH_TRIGGER, CH_TRIGGER,
                  CH_PARTNER, CH_TRIGGER, CH_PARTNER, CH_TRIGGER, CH_PARTNER};
        // The ninth hit steps backward, and so does the one after the
        // largest raw time.
        stamps = '{48'd0, 48'd1000, 48'd1050, 48'd1100, 48'd1200,
                   48'd1250, 48'd1300, 48'd1400, 48'd500, 48'd600,
                   48'd650, 48'd700, 48'd800, 48'd805, 48'd900,
                   48'd950, 48'd1000, 48'd1090, 48'd1100, 48'd1200,
                   48'hFFFF_FFFF_FFFF, 48'd5, 48'd10, 48'd20, 48'd30};
        in_idle_en = 1'b0;
        stall_en   = 1'b0;
        for (int i = 0; i < 25; i++)
            send_hit(chans[i], stamps[i]);
        cur_raw = stamps[24];
    endtask

    task automatic test_dense_settings();
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: configure('0, '0, '0, '0);
                1: configure(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
                2: configure(RST_BACKSTEP_GAP, RST_COINC_WINDOW, RST_SEARCH_START,
                             RST_ERROR_LIMIT);
                default: configure(CFG_W'(rand64()), CFG_W'($urandom_range(1, 300)),
                                   CFG_W'($urandom_range(0, 2000)),
                                   CFG_W'($urandom_range(0, 1000)));
            endcase
            // One setting runs with no idling on either side.
            in_idle_en = (s != 1);
            stall_en   = (s != 1);
            stream_hits(120, 150, 40);
        end
    endtask

    task automatic test_sparse_partners();
        configure(CFG_W'($urandom_range(0, 50000)), CFG_W'($urandom_range(50, 3000)),
                  CFG_W'($urandom_range(5000, 100000)), CFG_W'($urandom_range(0, 20000)));
        in_idle_en = 1'b1;
        stall_en   = 1'b1;
        stream_hits(150, 5000, 3);
    endtask

    task automatic test_output_backpressure();
        settle_block();
        in_idle_en = 1'b0;
        stall_en   = 1'b0;
        hold_reqs++;
        stream_hits(60, 150, 40);
    endtask

    task automatic test_random_noise();
        logic [63:0] r;
        configure(CFG_W'(rand64()), CFG_W'(rand64()), CFG_W'(rand64()), CFG_W'(rand64()));
        in_idle_en = 1'b1;
        stall_en   = 1'b1;
        for (int i = 0; i < 200; i++)
        begin
            r = rand64();
            send_hit(r[49:48], r[RAW_W-1:0]);
        end
        cur_raw = r[RAW_W-1:0];
    endtask

    task automatic test_steady_stream();
        configure(CFG_W'($urandom_range(0, 1000000)), CFG_W'($urandom_range(20, 200)),
                  RST_SEARCH_START, CFG_W'($urandom_range(100, 5000)));
        in_idle_en = 1'b0;
        stall_en   = 1'b0;
        stream_hits(200, 120, 40);
    endtask

    // Large alternating backward steps push the offset, and with it every
    // time, into saturation.
    task automatic test_time_saturation();
        logic [63:0] r;
        configure(CFG_W'(rand64()), CFG_W'($urandom_range(1, 1000)), CFG_W'(rand64()),
                  CFG_W'(rand64()));
        in_idle_en = 1'b0;
        stall_en   = 1'b0;
        for (int i = 0; i < 300; i++)
        begin
            r = rand64();
            send_hit(pick_channel(40), {16'hFFFF, r[31:0]});
            send_hit(pick_channel(40), {16'h0000, r[63:32]});
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_dense_settings();
        test_sparse_partners();
        test_output_backpressure();
        test_random_noise();
        test_steady_stream();
        test_time_saturation();
        settle_block();
        if (expected_reports.size() != 0)
        begin
            $display("time %0t: %0d results never arrived", $time, expected_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
